FILE: rtl/mmrn_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the min/max range normalizer
// no dependencies

package mmrn_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int FRAC_W    = 16;
  localparam int SAT_SHIFT = SAMPLE_W - FRAC_W;
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [SAMPLE_W-1:0] ONE_Q16    = SAMPLE_W'(1) << FRAC_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_APPLY   = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
    logic                first;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                copied;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_RANGE,
    S_SAT,
    S_DIV,
    S_WB
  } state_t;

  typedef enum logic [1:0] {
    ALU_DIFF,
    ALU_RANGE,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic                borrow;
    logic [SAMPLE_W:0]   diff;
  } alu_res_t;

endpackage

FILE: rtl/mmrn_alu.sv
`timescale 1ns / 1ps
// shared subtractor of the normalizer: sample offset, frame range and divider step
// depends on mmrn_pkg

module mmrn_alu import mmrn_pkg::*; (
  input  alu_op_t             op,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] fmin,
  input  logic [SAMPLE_W-1:0] fmax,
  input  logic [SAMPLE_W-1:0] rem,
  input  logic                shift_bit,
  input  logic [SAMPLE_W-1:0] range,
  output alu_res_t            res
);

  logic [SAMPLE_W:0]   opa;
  logic [SAMPLE_W-1:0] opb;
  logic [SAMPLE_W+1:0] sub;

  always_comb begin
    unique case (op)
      ALU_DIFF: begin
        opa = {1'b0, sample};
        opb = fmin;
      end
      ALU_RANGE: begin
        opa = {1'b0, fmax};
        opb = fmin;
      end
      ALU_DIV: begin
        opa = {rem, shift_bit};
        opb = range;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    sub        = {1'b0, opa} - {2'b00, opb};
    res.borrow = sub[SAMPLE_W+1];
    res.diff   = sub[SAMPLE_W:0];
  end

endmodule

FILE: rtl/min_max_range_normalizer.sv
`timescale 1ns / 1ps
// top level of the min/max range normalizer: handshakes, frame statistics, sequencer
// depends on mmrn_pkg and mmrn_alu

// A measure request gives no result and leaves the block idle, ready again in the next
// cycle. An apply request runs from acceptance through offset, range, overflow check,
// 24 restoring divider steps and write back into the output register; offset, range
// and divider steps share one 25-bit subtractor. Copied, flat-frame and below-minimum
// requests go from the offset step to write back. in_stall is high while a request is
// in work, and the write back waits while an earlier result is still held by out_stall.

module min_max_range_normalizer import mmrn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  state_t              state_r, state_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic                compress_r, compress_nxt;
  logic [SAMPLE_W-1:0] diff_r, diff_nxt;
  logic [SAMPLE_W-1:0] range_r, range_nxt;
  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] shift_r, shift_nxt;
  logic [SAMPLE_W-1:0] res_r, res_nxt;
  logic                copied_r, copied_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  alu_op_t  alu_op;
  alu_res_t alu_res;
  logic     in_take;
  logic     out_free;

  mmrn_alu u_alu (
    .op        (alu_op),
    .sample    (sample_r),
    .fmin      (min_r),
    .fmax      (max_r),
    .rem       (rem_r),
    .shift_bit (shift_r[SAMPLE_W-1]),
    .range     (range_r),
    .res       (alu_res)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= '0;
      max_r       <= '0;
      compress_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      compress_r  <= compress_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    diff_r     <= diff_nxt;
    range_r    <= range_nxt;
    rem_r      <= rem_nxt;
    shift_r    <= shift_nxt;
    res_r      <= res_nxt;
    copied_r   <= copied_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    compress_nxt  = compress_r;
    diff_nxt      = diff_r;
    range_nxt     = range_r;
    rem_nxt       = rem_r;
    shift_nxt     = shift_r;
    res_nxt       = res_r;
    copied_nxt    = copied_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    alu_op        = ALU_DIFF;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          compress_nxt = cfg_data;
        end
        if (in_take) begin
          if (in_data.req_type == REQ_MEASURE) begin
            if (in_data.first) begin
              min_nxt = in_data.sample;
              max_nxt = in_data.sample;
            end else begin
              if (in_data.sample < min_r) min_nxt = in_data.sample;
              if (in_data.sample > max_r) max_nxt = in_data.sample;
            end
          end else begin
            sample_nxt = in_data.sample;
            state_nxt  = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        alu_op   = ALU_DIFF;
        diff_nxt = alu_res.diff[SAMPLE_W-1:0];
        if (compress_r && (max_r <= ONE_Q16)) begin
          res_nxt    = sample_r;
          copied_nxt = 1'b1;
          state_nxt  = S_WB;
        end else begin
          copied_nxt = 1'b0;
          if ((max_r == min_r) || alu_res.borrow ||
              (alu_res.diff[SAMPLE_W-1:0] == '0)) begin
            res_nxt   = '0;
            state_nxt = S_WB;
          end else begin
            state_nxt = S_RANGE;
          end
        end
      end
      S_RANGE: begin
        alu_op    = ALU_RANGE;
        range_nxt = alu_res.diff[SAMPLE_W-1:0];
        rem_nxt   = {{SAT_SHIFT{1'b0}}, diff_r[SAMPLE_W-1:SAT_SHIFT]};
        shift_nxt = {diff_r[SAT_SHIFT-1:0], {FRAC_W{1'b0}}};
        cnt_nxt   = '0;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        // quotient overflows the field when offset >= range * 2^8
        if ({{SAT_SHIFT{1'b0}}, diff_r} >= {range_r, {SAT_SHIFT{1'b0}}}) begin
          res_nxt   = SAMPLE_MAX;
          state_nxt = S_WB;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        alu_op = ALU_DIV;
        if (!alu_res.borrow) begin
          rem_nxt = alu_res.diff[SAMPLE_W-1:0];
        end else begin
          rem_nxt = {rem_r[SAMPLE_W-2:0], shift_r[SAMPLE_W-1]};
        end
        res_nxt   = {res_r[SAMPLE_W-2:0], !alu_res.borrow};
        shift_nxt = {shift_r[SAMPLE_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.value  = res_r;
          out_data_nxt.copied = copied_r;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= max_r)
    else $error("frame minimum above frame maximum");

  a_rem_below_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < range_r)
    else $error("divider remainder not below range");

  a_copy_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.copied |-> compress_r)
    else $error("copied result without compress mode");

  a_apply_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.req_type == REQ_APPLY |=> state_r == S_DIFF)
    else $error("apply request did not start the sequencer");

  a_measure_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.req_type == REQ_MEASURE |=> state_r == S_IDLE)
    else $error("measure request left idle");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench of min_max_range_normalizer: a directed table, then random measure/apply frames
// checked against a behavioral model of the frame statistics and the rescale
// depends on mmrn_pkg and the normalizer rtl

module testbench;
  import mmrn_pkg::*;

  localparam logic MODE_RESCALE  = 1'b0;
  localparam logic MODE_COMPRESS = 1'b1;
  localparam bit   CHECKED       = 1'b1;
  localparam bit   PREDICTED     = 1'b0;
  localparam int   TOTAL_REQ     = 1450;
  localparam int   CALM_REQ      = 200;
  localparam int   SETTLE        = 40;
  localparam int   WATCHDOG      = 2000;

  typedef struct {
    logic      mode;
    in_item_t  req;
    bit        fixed;
    out_item_t res;
  } vec_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  bit        in_fixed = 1'b0;
  out_item_t in_fixed_res = '0;
  bit        calm = 1'b0;
  int        stall_left = 0;

  logic [SAMPLE_W-1:0] stat_min = '0;
  logic [SAMPLE_W-1:0] stat_max = '0;
  logic                compress_on = 1'b0;
  out_item_t           norm_queue[$];
  int                  errors = 0;
  int                  quiet_cycles = 0;
  int                  sent = 0;
  logic                mode_now = MODE_RESCALE;
  vec_t                vectors[$];
  logic [SAMPLE_W-1:0] frame_base = '0;
  logic [SAMPLE_W-1:0] frame_span = '0;

  min_max_range_normalizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] scale_to_range(logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W+FRAC_W:0] quot;
    if (stat_max <= stat_min || s <= stat_min) return '0;
    quot = {s - stat_min, {FRAC_W{1'b0}}} / (stat_max - stat_min);
    return (quot > SAMPLE_MAX) ? SAMPLE_MAX : quot[SAMPLE_W-1:0];
  endfunction

  task automatic predict_norm(in_item_t r, bit fixed, out_item_t fixed_res);
    out_item_t res;
    if (r.req_type == REQ_MEASURE) begin
      if (r.first) begin
        stat_min = r.sample;
        stat_max = r.sample;
      end else begin
        if (r.sample < stat_min) stat_min = r.sample;
        if (r.sample > stat_max) stat_max = r.sample;
      end
    end else begin
      if (compress_on && stat_max <= ONE_Q16) begin
        res = '{value: r.sample, copied: 1'b1};
      end else begin
        res = '{value: scale_to_range(r.sample), copied: 1'b0};
      end
      norm_queue.push_back(fixed ? fixed_res : res);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        compress_on = cfg_data;
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        predict_norm(in_data, in_fixed, in_fixed_res);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (norm_queue.size() == 0) begin
          $error("result with nothing pending: value %h copied %b",
                 out_data.value, out_data.copied);
          errors++;
        end else begin
          want = norm_queue.pop_front();
          if (out_data.value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, out_data.value);
            errors++;
          end
          if (out_data.copied !== want.copied) begin
            $error("copied: expected %b, actual %b", want.copied, out_data.copied);
            errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_req(in_item_t r, bit fixed, out_item_t res);
    in_valid <= 1'b1;
    in_data <= r;
    in_fixed <= fixed;
    in_fixed_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_data <= '{req_type: 1'($urandom), sample: SAMPLE_W'($urandom), first: 1'($urandom)};
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (norm_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_now = m;
  endtask

  task automatic add_row(logic m, logic rt, logic [SAMPLE_W-1:0] s, logic f, bit fixed,
                         logic [SAMPLE_W-1:0] v, logic c);
    vec_t row;
    row.mode = m;
    row.req = '{req_type: rt, sample: s, first: f};
    row.fixed = fixed;
    row.res = '{value: v, copied: c};
    vectors.push_back(row);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'($urandom_range(0, 'h18000));
      2: return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
      default: return frame_base + SAMPLE_W'($urandom_range(0, frame_span));
    endcase
  endfunction

  task automatic send_frame();
    in_item_t r;
    int n;
    frame_base = $urandom_range(0, 1) ? SAMPLE_W'($urandom)
                                      : SAMPLE_W'($urandom_range(0, ONE_Q16));
    frame_span = SAMPLE_W'($urandom) >> $urandom_range(0, SAMPLE_W - 1);
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      r.req_type = REQ_MEASURE;
      r.sample = frame_base + SAMPLE_W'($urandom_range(0, frame_span));
      // now and then a frame starts without its first flag
      r.first = (i == 0) && ($urandom_range(0, 7) != 0);
      sender_gap();
      send_req(r, PREDICTED, '0);
    end
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      r.req_type = REQ_APPLY;
      r.sample = pick_sample();
      r.first = 1'($urandom);
      sender_gap();
      send_req(r, PREDICTED, '0);
    end
  endtask

  initial begin
    in_item_t r;
    // flat frame after reset
    add_row(MODE_RESCALE, REQ_APPLY, 24'h123456, 1'b0, CHECKED, 24'h000000, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'hFFFFFF, 1'b0, CHECKED, 24'h000000, 1'b0);
    // range 1.0 .. 3.0
    add_row(MODE_RESCALE, REQ_MEASURE, 24'h010000, 1'b1, PREDICTED, '0, 1'b0);
    add_row(MODE_RESCALE, REQ_MEASURE, 24'h030000, 1'b0, PREDICTED, '0, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'h030000, 1'b0, CHECKED, 24'h010000, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'h010000, 1'b0, CHECKED, 24'h000000, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'h000000, 1'b0, CHECKED, 24'h000000, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'hFFFFFF, 1'b0, CHECKED, 24'h7F7FFF, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'h020000, 1'b0, CHECKED, 24'h008000, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'h028000, 1'b1, PREDICTED, '0, 1'b0);
    // full range
    add_row(MODE_RESCALE, REQ_MEASURE, 24'h000000, 1'b0, PREDICTED, '0, 1'b0);
    add_row(MODE_RESCALE, REQ_MEASURE, 24'hFFFFFF, 1'b0, PREDICTED, '0, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'hFFFFFF, 1'b0, CHECKED, 24'h010000, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'h7FFFFF, 1'b0, PREDICTED, '0, 1'b0);
    // flat frame from a restart
    add_row(MODE_RESCALE, REQ_MEASURE, 24'h555555, 1'b1, PREDICTED, '0, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'h555555, 1'b0, CHECKED, 24'h000000, 1'b0);
    add_row(MODE_RESCALE, REQ_APPLY, 24'hAAAAAA, 1'b0, CHECKED, 24'h000000, 1'b0);
    // compress mode
    add_row(MODE_COMPRESS, REQ_APPLY, 24'hAAAAAA, 1'b0, CHECKED, 24'h000000, 1'b0);
    add_row(MODE_COMPRESS, REQ_MEASURE, 24'h008000, 1'b1, PREDICTED, '0, 1'b0);
    add_row(MODE_COMPRESS, REQ_APPLY, 24'h00C000, 1'b0, CHECKED, 24'h00C000, 1'b1);
    add_row(MODE_COMPRESS, REQ_APPLY, 24'hFFFFFF, 1'b0, CHECKED, 24'hFFFFFF, 1'b1);
    add_row(MODE_COMPRESS, REQ_MEASURE, 24'h010000, 1'b0, PREDICTED, '0, 1'b0);
    add_row(MODE_COMPRESS, REQ_APPLY, 24'h00C000, 1'b0, CHECKED, 24'h00C000, 1'b1);
    add_row(MODE_COMPRESS, REQ_MEASURE, 24'h010001, 1'b0, PREDICTED, '0, 1'b0);
    add_row(MODE_COMPRESS, REQ_APPLY, 24'h00C000, 1'b0, PREDICTED, '0, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].mode != mode_now) write_mode(vectors[i].mode);
      sender_gap();
      send_req(vectors[i].req, vectors[i].fixed, vectors[i].res);
    end

    for (int p = 0; p < 4; p++) begin
      write_mode(p[0] ? MODE_COMPRESS : MODE_RESCALE);
      while (sent < TOTAL_REQ * (p + 1) / 4) begin
        if (sent >= TOTAL_REQ - CALM_REQ) calm <= 1'b1;
        if (!calm && $urandom_range(0, 15) == 0) drain();
        if ($urandom_range(0, 7) == 0) begin
          r = '{req_type: 1'($urandom), sample: pick_sample(), first: 1'($urandom)};
          sender_gap();
          send_req(r, PREDICTED, '0);
        end else begin
          send_frame();
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: min_max_range_normalizer.f
rtl/mmrn_pkg.sv
rtl/mmrn_alu.sv
rtl/min_max_range_normalizer.sv
test/testbench.sv
